### hw/rtl/tcfa_pkg.sv
// Types and constants shared by the tactile CAN frame assembler.
`timescale 1ns / 1ps
`default_nettype none
package tcfa_pkg;

    localparam int unsigned ID_W    = 11;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned VAL_W   = 18;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CFG_A_W = 3;

    typedef logic [ID_W-1:0]          t_frame_id;
    typedef logic [DATA_W-1:0]        t_data;
    typedef logic [WORD_W-1:0]        t_word;
    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic [IDX_W-1:0]         t_item_idx;
    typedef logic [CFG_A_W-1:0]       t_cfg_addr;

    localparam t_frame_id STAGE_IDS [4] = '{11'h405, 11'h407, 11'h409, 11'h40b};
    localparam t_frame_id ID_PROX       = 11'h601;

    localparam t_cfg_addr CFG_MAP     = 3'd0;
    localparam t_cfg_addr CFG_BIAS_A  = 3'd1;
    localparam t_cfg_addr CFG_BIAS_B  = 3'd2;
    localparam t_cfg_addr CFG_BIAS_C  = 3'd3;
    localparam t_cfg_addr CFG_BIAS_D  = 3'd4;
    localparam t_cfg_addr CFG_UPPER   = 3'd5;
    localparam t_cfg_addr CFG_LOWER   = 3'd6;

    localparam t_data  MAP_RST   = 64'hFEDC_BA98_7654_3210;
    localparam t_value UPPER_RST = 18'sd3000;
    localparam t_value LOWER_RST = -18'sd100;

endpackage
`default_nettype wire

### hw/rtl/tcfa_if.sv
// Handshake channels of the frame assembler: frames in, results out, config writes.
`timescale 1ns / 1ps
`default_nettype none
interface tcfa_frame_if;
    logic                valid;
    logic                ready;
    tcfa_pkg::t_frame_id frame_id;
    tcfa_pkg::t_data     payload;

    modport source (output valid, frame_id, payload, input ready);
    modport sink   (input valid, frame_id, payload, output ready);
endinterface

interface tcfa_result_if;
    logic                valid;
    logic                ready;
    tcfa_pkg::t_item_idx item_index;
    tcfa_pkg::t_value    item_value;
    logic                out_of_range;
    logic                last_item;

    modport source (output valid, item_index, item_value, out_of_range, last_item,
                    input ready);
    modport sink   (input valid, item_index, item_value, out_of_range, last_item,
                    output ready);
endinterface

interface tcfa_cfg_if;
    logic                valid;
    logic                ready;
    tcfa_pkg::t_cfg_addr addr;
    tcfa_pkg::t_data     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/tcfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcfa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/tactile_can_frame_assembler_top.sv
// Top level of the tactile CAN frame assembler.
//
// Frames 0x405, 0x407, 0x409, 0x40b and 0x601 must arrive in that order; any
// other frame is taken and dropped. A data frame holds ready low while its four
// words are written one per cycle into the channel RAM through the channel map.
// The proximity frame starts the output run: the channel RAM is read once to
// build the channel sum, the limits are checked, and the RAM is read again to
// send NUM_CHANNELS + 2 words at up to one word per cycle, so a completed set
// holds ready low until its last word is issued, a run that the single RAM read
// port makes longer.
// Channels not written in a set read as zero (per-channel valid bits). A flagged set
// halts the block: further frames are taken and dropped until reset. The config
// port is always ready and must be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module tactile_can_frame_assembler_top #(
    parameter int unsigned NUM_CHANNELS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tcfa_frame_if.sink     i_frame,
    tcfa_result_if.source  o_result,
    tcfa_cfg_if.sink       i_cfg
);
    localparam int unsigned CH_W  = $clog2(NUM_CHANNELS);
    localparam int unsigned SUM_W = tcfa_pkg::VAL_W + $clog2(NUM_CHANNELS + 1);
    localparam logic [4:0]  NCH5  = 5'(NUM_CHANNELS);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);
    localparam tcfa_pkg::t_item_idx ITEM_LAST = tcfa_pkg::IDX_W'(NUM_CHANNELS + 1);
    localparam logic signed [SUM_W-1:0] NCH_S = SUM_W'(NUM_CHANNELS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_SUM_END,
        S_CMP,
        S_EMIT
    } t_state;

    t_state                 r_state;
    tcfa_pkg::t_data        r_map;
    tcfa_pkg::t_data        r_bias [4];
    tcfa_pkg::t_value       r_upper;
    tcfa_pkg::t_value       r_lower;
    logic [2:0]             r_stage;
    logic                   r_halted;
    logic [NUM_CHANNELS-1:0] r_vld;
    tcfa_pkg::t_data        r_payload;
    logic [1:0]             r_word;
    tcfa_pkg::t_word        r_prox0;
    tcfa_pkg::t_word        r_prox1;
    logic [CH_W-1:0]        r_idx;
    logic [CH_W-1:0]        r_ch;
    logic                   r_pend;
    logic signed [SUM_W-1:0] r_sum;
    logic                   r_flag;
    tcfa_pkg::t_item_idx    r_item;
    logic                   r_out_vld;
    tcfa_pkg::t_item_idx    r_out_idx;
    tcfa_pkg::t_value       r_out_val;
    logic                   r_out_flag;
    logic                   r_out_last;

    logic                   w_frame_acc;
    logic [3:0]             w_word_idx;
    logic [3:0]             w_target;
    logic                   w_tgt_ok;
    logic                   w_free;
    logic                   w_we;
    logic                   w_re;
    logic [CH_W-1:0]        w_raddr;
    tcfa_pkg::t_word        w_rdata;
    tcfa_pkg::t_word        w_raw;
    logic [3:0]             w_ch4;
    tcfa_pkg::t_word        w_bias;
    tcfa_pkg::t_value       w_corr;
    logic signed [SUM_W-1:0] w_up_lim;
    logic signed [SUM_W-1:0] w_lo_lim;

    assign i_frame.ready = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign w_frame_acc   = i_frame.valid && (r_state == S_IDLE);

    assign w_word_idx = {r_stage[1:0], r_word};
    assign w_target   = r_map[w_word_idx*4 +: 4];
    assign w_tgt_ok   = ({1'b0, w_target} < NCH5);
    assign w_we       = (r_state == S_WRITE) && w_tgt_ok;
    assign w_free     = !r_out_vld || o_result.ready;

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx;
        case (r_state)
            S_SUM: begin
                w_re    = 1'b1;
                w_raddr = r_idx;
            end
            S_CMP: begin
                w_re    = 1'b1;
                w_raddr = '0;
            end
            S_EMIT: begin
                w_re    = w_free && (r_item >= 5'd2) && (r_ch != CH_LAST);
                w_raddr = r_ch + 1'b1;
            end
            default: begin
                w_re    = 1'b0;
                w_raddr = r_idx;
            end
        endcase
    end

    tcfa_ram #(
        .WIDTH (tcfa_pkg::WORD_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ch_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_target[CH_W-1:0]),
        .i_wdata (r_payload[r_word*16 +: 16]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // bias-corrected value of the channel currently on the RAM read port
    assign w_raw    = r_vld[r_ch] ? w_rdata : '0;
    assign w_ch4    = 4'(r_ch);
    assign w_bias   = r_bias[w_ch4[3:2]][w_ch4[1:0]*16 +: 16];
    assign w_corr   = {2'b00, w_raw} - {{2{w_bias[15]}}, w_bias};
    assign w_up_lim = SUM_W'(r_upper) * NCH_S;
    assign w_lo_lim = SUM_W'(r_lower) * NCH_S;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_map     <= tcfa_pkg::MAP_RST;
            r_bias    <= '{default: '0};
            r_upper   <= tcfa_pkg::UPPER_RST;
            r_lower   <= tcfa_pkg::LOWER_RST;
            r_stage   <= '0;
            r_halted  <= 1'b0;
            r_vld     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.addr)
                    tcfa_pkg::CFG_MAP:    r_map     <= i_cfg.data;
                    tcfa_pkg::CFG_BIAS_A: r_bias[0] <= i_cfg.data;
                    tcfa_pkg::CFG_BIAS_B: r_bias[1] <= i_cfg.data;
                    tcfa_pkg::CFG_BIAS_C: r_bias[2] <= i_cfg.data;
                    tcfa_pkg::CFG_BIAS_D: r_bias[3] <= i_cfg.data;
                    tcfa_pkg::CFG_UPPER:  r_upper   <= i_cfg.data[tcfa_pkg::VAL_W-1:0];
                    tcfa_pkg::CFG_LOWER:  r_lower   <= i_cfg.data[tcfa_pkg::VAL_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_EMIT && w_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_result.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_frame_acc && !r_halted) begin
                        if (r_stage < 3'd4 &&
                            i_frame.frame_id == tcfa_pkg::STAGE_IDS[r_stage[1:0]]) begin
                            r_payload <= i_frame.payload;
                            r_word    <= '0;
                            r_state   <= S_WRITE;
                        end else if (r_stage == 3'd4 &&
                                     i_frame.frame_id == tcfa_pkg::ID_PROX) begin
                            r_prox0 <= i_frame.payload[15:0];
                            r_prox1 <= i_frame.payload[31:16];
                            r_sum   <= '0;
                            r_idx   <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_WRITE: begin
                    if (w_tgt_ok) begin
                        r_vld[w_target[CH_W-1:0]] <= 1'b1;
                    end
                    r_word <= r_word + 1'b1;
                    if (r_word == 2'd3) begin
                        r_stage <= r_stage + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SUM: begin
                    r_pend <= 1'b1;
                    r_ch   <= r_idx;
                    if (r_pend) begin
                        r_sum <= r_sum + SUM_W'(w_corr);
                    end
                    if (r_idx == CH_LAST) begin
                        r_state <= S_SUM_END;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SUM_END: begin
                    r_sum   <= r_sum + SUM_W'(w_corr);
                    r_pend  <= 1'b0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_flag  <= (r_sum >= w_up_lim) || (r_sum <= w_lo_lim);
                    r_ch    <= '0;
                    r_item  <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_out_idx  <= r_item;
                        r_out_flag <= r_flag;
                        r_out_last <= (r_item == ITEM_LAST);
                        if (r_item == 5'd0) begin
                            r_out_val <= tcfa_pkg::VAL_W'({2'b00, r_prox0});
                        end else if (r_item == 5'd1) begin
                            r_out_val <= tcfa_pkg::VAL_W'({2'b00, r_prox1});
                        end else begin
                            r_out_val <= w_corr;
                            if (r_ch != CH_LAST) begin
                                r_ch <= r_ch + 1'b1;
                            end
                        end
                        r_item <= r_item + 1'b1;
                        if (r_item == ITEM_LAST) begin
                            r_stage  <= '0;
                            r_vld    <= '0;
                            r_halted <= r_flag;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.item_index   = r_out_idx;
    assign o_result.item_value   = r_out_val;
    assign o_result.out_of_range = r_out_flag;
    assign o_result.last_item    = r_out_last;
endmodule
`default_nettype wire

### hw/rtl/tcfa_checker.sv
// Port-level checks of the frame assembler output, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tcfa_checker #(
    parameter int unsigned NUM_CHANNELS = 16
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                i_ready,
    input wire tcfa_pkg::t_item_idx i_item_index,
    input wire tcfa_pkg::t_value    i_item_value,
    input wire logic                i_out_of_range,
    input wire logic                i_last_item
);
    localparam tcfa_pkg::t_item_idx ITEM_LAST = tcfa_pkg::IDX_W'(NUM_CHANNELS + 1);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_item_index) && $stable(i_item_value))
        else $error("result word changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last_item == (i_item_index == ITEM_LAST)))
        else $error("last flag does not match final index");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_item_index <= ITEM_LAST))
        else $error("result index out of range");

    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_last_item && i_out_of_range |=> !i_valid)
        else $error("output after flagged set");
endmodule

bind tactile_can_frame_assembler_top tcfa_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_tcfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_item_index   (o_result.item_index),
    .i_item_value   (o_result.item_value),
    .i_out_of_range (o_result.out_of_range),
    .i_last_item    (o_result.last_item)
);
`default_nettype wire

### tb/tb_tactile_can_frame_assembler_top.sv
// Self-checking testbench of the tactile CAN frame assembler: frame stimulus, prediction, checks.
`timescale 1ns / 1ps
module tb_tactile_can_frame_assembler_top;

    localparam int NCH             = 16;
    localparam int SETTLE_CYCLES   = 2 * NCH + 30;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RANDOM_QUOTA    = 48;
    localparam tcfa_pkg::t_cfg_addr CFG_UNMAPPED = 3'd7;

    typedef struct {
        tcfa_pkg::t_item_idx idx;
        tcfa_pkg::t_value    value;
        logic                oor;
        logic                last;
    } t_exp_word;

    typedef struct {
        tcfa_pkg::t_cfg_addr addr;
        tcfa_pkg::t_data     data;
    } t_reg_write;

    // Mirrors the assembler state and holds the words it owes us.
    class tactile_set_predictor;
        tcfa_pkg::t_data   chan_map;
        tcfa_pkg::t_data   bias_grp [4];
        tcfa_pkg::t_value  upper_lim;
        tcfa_pkg::t_value  lower_lim;
        int                stage;
        tcfa_pkg::t_word   chan_raw [NCH];
        bit                halted;
        t_exp_word         expected_words [$];
        int                errors;
        int                frames_taken;
        int                sets_done;
        int                words_checked;

        function new();
            chan_map = tcfa_pkg::MAP_RST;
            foreach (bias_grp[g]) bias_grp[g] = '0;
            upper_lim = tcfa_pkg::UPPER_RST;
            lower_lim = tcfa_pkg::LOWER_RST;
            stage     = 0;
            halted    = 1'b0;
            foreach (chan_raw[c]) chan_raw[c] = '0;
        endfunction

        function void write_reg(tcfa_pkg::t_cfg_addr addr, tcfa_pkg::t_data data);
            case (addr)
                tcfa_pkg::CFG_MAP: chan_map = data;
                tcfa_pkg::CFG_BIAS_A, tcfa_pkg::CFG_BIAS_B,
                tcfa_pkg::CFG_BIAS_C, tcfa_pkg::CFG_BIAS_D: begin
                    bias_grp[addr - tcfa_pkg::CFG_BIAS_A] = data;
                end
                tcfa_pkg::CFG_UPPER: upper_lim = data[tcfa_pkg::VAL_W-1:0];
                tcfa_pkg::CFG_LOWER: lower_lim = data[tcfa_pkg::VAL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_frame(tcfa_pkg::t_frame_id id, tcfa_pkg::t_data payload);
            int              ch;
            int              val [NCH];
            int              raw;
            int              bias;
            tcfa_pkg::t_word bias_w;
            longint          sum;
            longint          hi_thr;
            longint          lo_thr;
            bit              flag;
            t_exp_word       w;
            if (halted) return;
            if (stage < 4) begin
                if (id != tcfa_pkg::STAGE_IDS[stage]) return;
                for (int i = 0; i < 4; i++) begin
                    ch = chan_map[4 * (4 * stage + i) +: 4];
                    if (ch < NCH) chan_raw[ch] = payload[16 * i +: 16];
                end
                stage++;
                frames_taken++;
                return;
            end
            if (id != tcfa_pkg::ID_PROX) return;
            frames_taken++;
            sum = 0;
            for (int c = 0; c < NCH; c++) begin
                bias_w = bias_grp[c / 4][16 * (c % 4) +: 16];
                bias   = $signed(bias_w);
                raw    = chan_raw[c];
                val[c] = raw - bias;
                sum   += val[c];
            end
            hi_thr = upper_lim;
            hi_thr = hi_thr * NCH;
            lo_thr = lower_lim;
            lo_thr = lo_thr * NCH;
            flag   = (sum >= hi_thr) || (sum <= lo_thr);
            for (int k = 0; k < NCH + 2; k++) begin
                w.idx   = k[tcfa_pkg::IDX_W-1:0];
                w.value = (k < 2) ? {2'b00, payload[16 * k +: 16]}
                                  : val[k - 2][tcfa_pkg::VAL_W-1:0];
                w.oor   = flag;
                w.last  = (k == NCH + 1);
                expected_words.push_back(w);
            end
            stage = 0;
            foreach (chan_raw[c]) chan_raw[c] = '0;
            halted = flag;
            sets_done++;
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void check_result(tcfa_pkg::t_item_idx idx, tcfa_pkg::t_value value,
                                   logic oor, logic last);
            t_exp_word want;
            words_checked++;
            if (expected_words.size() == 0) begin
                fail_note($sformatf("unexpected word idx %0d val %0d oor %0b last %0b",
                                    idx, value, oor, last));
                return;
            end
            want = expected_words.pop_front();
            if (want.idx !== idx || want.value !== value || want.oor !== oor
                    || want.last !== last) begin
                fail_note($sformatf({"word mismatch: expected idx %0d val %0d oor %0b last %0b,",
                                     " got idx %0d val %0d oor %0b last %0b"},
                                    want.idx, want.value, want.oor, want.last,
                                    idx, value, oor, last));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;

    tactile_set_predictor set_pred = new();
    t_reg_write           reg_plan [$];

    tcfa_frame_if  frame_ch();
    tcfa_result_if result_ch();
    tcfa_cfg_if    cfg_ch();

    tactile_can_frame_assembler_top #(.NUM_CHANNELS(NCH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            set_pred.check_result(result_ch.item_index, result_ch.item_value,
                                  result_ch.out_of_range, result_ch.last_item);
        end
        result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     quiet_cycles, set_pred.expected_words.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_frame(input tcfa_pkg::t_frame_id id, input tcfa_pkg::t_data pl);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_ch.valid    <= 1'b1;
        frame_ch.frame_id <= id;
        frame_ch.payload  <= pl;
        @(posedge i_clk);
        while (!frame_ch.ready) @(posedge i_clk);
        set_pred.note_frame(id, pl);
    endtask

    task automatic send_set(input tcfa_pkg::t_data p0, input tcfa_pkg::t_data p1,
                            input tcfa_pkg::t_data p2, input tcfa_pkg::t_data p3,
                            input tcfa_pkg::t_data prox);
        send_frame(tcfa_pkg::STAGE_IDS[0], p0);
        send_frame(tcfa_pkg::STAGE_IDS[1], p1);
        send_frame(tcfa_pkg::STAGE_IDS[2], p2);
        send_frame(tcfa_pkg::STAGE_IDS[3], p3);
        send_frame(tcfa_pkg::ID_PROX, prox);
    endtask

    // Drain all owed words, then give the block time to finish any data frame.
    task automatic settle();
        frame_ch.valid <= 1'b0;
        while (set_pred.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void plan_reg(input tcfa_pkg::t_cfg_addr addr,
                                     input tcfa_pkg::t_data data);
        reg_plan.push_back('{addr: addr, data: data});
    endfunction

    task automatic write_regs();
        while (reg_plan.size() != 0) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= reg_plan[0].addr;
            cfg_ch.data  <= reg_plan[0].data;
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            set_pred.write_reg(reg_plan[0].addr, reg_plan[0].data);
            void'(reg_plan.pop_front());
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Limits stay out of reach of any 16-channel set so the block never halts here.
    task automatic random_config(input bit extreme);
        int hi;
        int lo;
        hi = extreme ? 131071 : $urandom_range(131071, 98304);
        lo = extreme ? -65536 : -int'($urandom_range(65536, 32768));
        plan_reg(tcfa_pkg::CFG_MAP,
                 ($urandom_range(3, 0) == 0) ? tcfa_pkg::MAP_RST : {$urandom, $urandom});
        for (int g = 0; g < 4; g++) begin
            plan_reg(tcfa_pkg::t_cfg_addr'(tcfa_pkg::CFG_BIAS_A + g), {$urandom, $urandom});
        end
        plan_reg(tcfa_pkg::CFG_UPPER, tcfa_pkg::t_data'(hi));
        plan_reg(tcfa_pkg::CFG_LOWER, tcfa_pkg::t_data'(lo));
        write_regs();
    endtask

    task automatic run_random(input int quota);
        int                  first;
        int                  r;
        tcfa_pkg::t_frame_id id;
        tcfa_pkg::t_data     pl;
        first = set_pred.frames_taken;
        while (set_pred.frames_taken - first < quota || set_pred.stage != 0) begin
            r = $urandom_range(99, 0);
            if (r < 7) begin
                id = tcfa_pkg::t_frame_id'($urandom_range(2047, 0));
            end else if (r < 14) begin
                id = ($urandom_range(4, 0) == 4) ? tcfa_pkg::ID_PROX
                                                 : tcfa_pkg::STAGE_IDS[$urandom_range(3, 0)];
            end else begin
                id = (set_pred.stage < 4) ? tcfa_pkg::STAGE_IDS[set_pred.stage]
                                          : tcfa_pkg::ID_PROX;
            end
            pl = {$urandom, $urandom};
            if ($urandom_range(9, 0) == 0) pl = ($urandom_range(1, 0) != 0) ? '1 : '0;
            send_frame(id, pl);
        end
    endtask

    initial begin
        int              variant;
        int              lim;
        tcfa_pkg::t_data p0;
        tcfa_pkg::t_data pn;
        i_rst_n            = 1'b0;
        frame_ch.valid     = 1'b0;
        frame_ch.frame_id  = '0;
        frame_ch.payload   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.addr        = '0;
        cfg_ch.data        = '0;
        result_ch.ready    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: stray ids, repeated and early ids, sum one below the upper limit
        send_frame(tcfa_pkg::ID_PROX, '1);
        send_frame(11'h000, {$urandom, $urandom});
        send_frame(11'h7ff, '1);
        send_frame(tcfa_pkg::STAGE_IDS[0], tcfa_pkg::t_data'(16 * 3000 - 1));
        send_frame(tcfa_pkg::STAGE_IDS[0], '1);
        send_frame(tcfa_pkg::STAGE_IDS[1], '0);
        send_frame(tcfa_pkg::STAGE_IDS[2], '0);
        send_frame(tcfa_pkg::STAGE_IDS[3], '0);
        send_frame(tcfa_pkg::STAGE_IDS[0], '1);
        send_frame(tcfa_pkg::ID_PROX, '1);
        settle();

        // every word onto channel 0, extreme biases: largest and smallest values
        plan_reg(tcfa_pkg::CFG_MAP, '0);
        plan_reg(tcfa_pkg::CFG_BIAS_A, {16'h7fff, 16'h7fff, 16'h7fff, 16'h8000});
        plan_reg(tcfa_pkg::CFG_BIAS_B, {4{16'h7fff}});
        plan_reg(tcfa_pkg::CFG_BIAS_C, {4{16'h7fff}});
        plan_reg(tcfa_pkg::CFG_BIAS_D, {4{16'h7fff}});
        plan_reg(tcfa_pkg::CFG_UPPER, tcfa_pkg::t_data'(131071));
        plan_reg(tcfa_pkg::CFG_LOWER, tcfa_pkg::t_data'(-65536));
        plan_reg(CFG_UNMAPPED, {$urandom, $urandom});
        write_regs();
        send_set('1, '1, '1, '1, {$urandom, $urandom});
        settle();

        plan_reg(tcfa_pkg::CFG_MAP, '1);
        write_regs();
        send_set('0, '0, '0, '0, '0);
        settle();

        // sum one above the lower limit
        plan_reg(tcfa_pkg::CFG_MAP, tcfa_pkg::MAP_RST);
        plan_reg(tcfa_pkg::CFG_BIAS_A, tcfa_pkg::t_data'(16 * 100 - 1));
        plan_reg(tcfa_pkg::CFG_BIAS_B, '0);
        plan_reg(tcfa_pkg::CFG_BIAS_C, '0);
        plan_reg(tcfa_pkg::CFG_BIAS_D, '0);
        plan_reg(tcfa_pkg::CFG_LOWER, tcfa_pkg::t_data'(-100));
        write_regs();
        send_set('0, '0, '0, '0, {$urandom, $urandom});
        settle();

        random_config(1'b1);
        run_random(RANDOM_QUOTA);
        settle();

        send_idle_pct = 78;
        random_config(1'b0);
        run_random(RANDOM_QUOTA);
        settle();

        send_idle_pct = 0;
        stall_pct     = 78;
        random_config(1'b0);
        run_random(RANDOM_QUOTA);
        settle();

        send_idle_pct = 37;
        stall_pct     = 37;
        random_config(1'b0);
        run_random(RANDOM_QUOTA);
        settle();

        // trip a limit exactly, or with the lower limit at its top, then confirm the halt
        variant = $urandom_range(2, 0);
        lim     = $urandom_range(2000, 1);
        p0      = '0;
        pn      = '0;
        plan_reg(tcfa_pkg::CFG_MAP, tcfa_pkg::MAP_RST);
        for (int g = 0; g < 4; g++) begin
            plan_reg(tcfa_pkg::t_cfg_addr'(tcfa_pkg::CFG_BIAS_A + g), '0);
        end
        case (variant)
            0: begin
                plan_reg(tcfa_pkg::CFG_UPPER, tcfa_pkg::t_data'(lim));
                plan_reg(tcfa_pkg::CFG_LOWER, tcfa_pkg::t_data'(-65536));
                p0 = tcfa_pkg::t_data'(16 * lim);
            end
            1: begin
                plan_reg(tcfa_pkg::CFG_BIAS_A, tcfa_pkg::t_data'(16 * lim));
                plan_reg(tcfa_pkg::CFG_UPPER, tcfa_pkg::t_data'(131071));
                plan_reg(tcfa_pkg::CFG_LOWER, tcfa_pkg::t_data'(-lim));
            end
            default: begin
                plan_reg(tcfa_pkg::CFG_UPPER, tcfa_pkg::t_data'(131071));
                plan_reg(tcfa_pkg::CFG_LOWER, tcfa_pkg::t_data'(131071));
                p0 = {$urandom, $urandom};
                pn = {$urandom, $urandom};
            end
        endcase
        write_regs();
        send_set(p0, pn, pn, pn, {$urandom, $urandom});
        send_frame(tcfa_pkg::t_frame_id'($urandom_range(2047, 0)), {$urandom, $urandom});
        send_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        settle();

        $display("covered %0d accepted frames, %0d completed sets, %0d result words checked",
                 set_pred.frames_taken, set_pred.sets_done, set_pred.words_checked);
        $display("sender/receiver idle mixes 0/0 78/0 0/78 37/37; limit trip (case %0d) %s",
                 variant, set_pred.halted ? "halted the block" : "did not halt the block");
        if (set_pred.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", set_pred.errors);
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/tcfa_pkg.sv
hw/rtl/tcfa_if.sv
hw/rtl/tcfa_ram.sv
hw/rtl/tactile_can_frame_assembler_top.sv
hw/rtl/tcfa_checker.sv
tb/tb_tactile_can_frame_assembler_top.sv
